// ----- hdl/eabs_pkg.sv -----
// ----------------------------------------------------------------------------
// eabs_pkg
// Shared types and constants of the edge-aware 3x3 box smoother: field
// widths, register indexes, the controller/datapath command and status
// words, and the reciprocal lookup used for the mean.
// ----------------------------------------------------------------------------
package eabs_pkg;

  localparam int SMP_W   = 8;     // raw height sample
  localparam int CFG_W   = 13;    // grid_width / grid_height registers
  localparam int HGT_W   = 13;    // row counter, holds 0..4096
  localparam int ROW_W   = 12;    // result row field
  localparam int COL_W   = 12;    // result column field
  localparam int SUM_W   = 12;    // up to 9 * 255
  localparam int CNT_W   = 4;     // up to 9 cells
  localparam int RCP_W   = 25;    // reciprocal, up to 2^24
  localparam int RES_W   = 16;    // 8.8 mean
  localparam int PROD_W  = SUM_W + RCP_W;
  localparam int RCP_SH  = 16;    // (sum * 256 * rcp) >> 24 == (sum * rcp) >> 16

  localparam int MAX_HEIGHT = 4096;
  localparam logic [CFG_W-1:0] GRID_RESET = 13'd2049;

  // APB register map: word index taken from paddr[2]
  localparam int ADDR_W = 3;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // request kinds carried in tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_smp;   // capture sample, launch line store read
    logic commit;     // write line stores, shift window, advance counters
    logic sum_win;    // sum the window for the pending result
    logic load_fl;    // capture flush column, clear accumulator
    logic fl_rd;      // launch line store read for the current tap
    logic fl_acc;     // add the tap's read data
    logic mul;        // multiply sum by reciprocal of count
    logic emit;       // load the output register
  } eabs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic smp_ok;     // sample belongs to the frame
    logic fl_ok;      // flush tick has a result to give
    logic pend_any;   // captured sample produces at least one result
    logic pend_more;  // another result remains after the one in flight
    logic tap_last;   // last flush tap
    logic out_free;   // output register can take a word
  } eabs_stat_t;

  // ceil(2^24 / count); exact floor(sum*256/count) for all sums of up to 9 cells
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RCP_W-1:0] r;
    case (count)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/eabs_ctrl.sv -----
// ----------------------------------------------------------------------------
// eabs_ctrl
// Sequencer of the smoother: takes one word at a time and steps the datapath
// through line store access, window sum or flush taps, multiply and emit.
// ----------------------------------------------------------------------------
module eabs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  eabs_pkg::eabs_stat_t  stat,
  output eabs_pkg::eabs_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FACC = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == eabs_pkg::REQ_SAMPLE) begin
            if (stat.smp_ok) begin
              cmd.load_smp = 1'b1;
              state_next   = S_SRD;
            end
          end else if (stat.fl_ok) begin
            cmd.load_fl = 1'b1;
            state_next  = S_FRD;
          end
        end
      end
      S_SRD: begin
        cmd.commit = 1'b1;
        state_next = stat.pend_any ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum_win = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.pend_more ? S_SUM : S_IDLE;
        end
      end
      S_FRD: begin
        cmd.fl_rd  = 1'b1;
        state_next = S_FACC;
      end
      S_FACC: begin
        cmd.fl_acc = 1'b1;
        state_next = stat.tap_last ? S_MUL : S_FRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/eabs_dp.sv -----
// ----------------------------------------------------------------------------
// eabs_dp
// Datapath of the smoother: two line stores, the 3x3 window, raster and
// flush counters, the masked sum, the reciprocal multiply and the output
// register.
// ----------------------------------------------------------------------------
module eabs_dp #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_width,
  input  logic [eabs_pkg::HGT_W-1:0]          eff_height,
  input  logic [eabs_pkg::SMP_W-1:0]          in_sample,
  input  eabs_pkg::eabs_cmd_t                 cmd,
  output eabs_pkg::eabs_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [eabs_pkg::RES_W-1:0]          out_smoothed,
  output logic [eabs_pkg::ROW_W-1:0]          out_row,
  output logic [eabs_pkg::COL_W-1:0]          out_col,
  output logic                                out_last
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int SMP_W  = eabs_pkg::SMP_W;
  localparam int HGT_W  = eabs_pkg::HGT_W;
  localparam int ROW_W  = eabs_pkg::ROW_W;
  localparam int COL_W  = eabs_pkg::COL_W;
  localparam int SUM_W  = eabs_pkg::SUM_W;
  localparam int CNT_W  = eabs_pkg::CNT_W;
  localparam int RES_W  = eabs_pkg::RES_W;
  localparam int PROD_W = eabs_pkg::PROD_W;
  localparam int RCP_SH = eabs_pkg::RCP_SH;

  // line stores: a = previous row, b = the row before it
  logic [SMP_W-1:0] store_a [MAX_WIDTH];
  logic [SMP_W-1:0] store_b [MAX_WIDTH];
  logic [SMP_W-1:0] rd_a;
  logic [SMP_W-1:0] rd_b;
  logic             mem_re;
  logic [CW-1:0]    rd_addr;

  logic [SMP_W-1:0] win [9];

  logic [CW-1:0]    col_cnt;
  logic [HGT_W-1:0] row_cnt;
  logic [CW-1:0]    fl_cnt;

  logic [CW-1:0]    cap_c;
  logic [HGT_W-1:0] cap_r;
  logic [SMP_W-1:0] cap_smp;
  logic             pend_first;
  logic             pend_second;
  logic             has_first;
  logic             has_second;

  logic [1:0]       tap;
  logic [CW-1:0]    tap_col;
  logic             tap_ok;

  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_cnt;
  logic [ROW_W-1:0] res_row;
  logic [CW-1:0]    res_col;
  logic             res_last;
  logic             res_flush;
  logic [RES_W-1:0] quot;

  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_cnt;
  logic [PROD_W-1:0] prod;
  logic             col_wrap;
  logic             clear_frame;

  // ---- status ----
  assign has_first  = (cap_r != '0) && (cap_c != '0);
  assign has_second = (cap_r != '0) && (WW'(cap_c) + WW'(1) == eff_width);

  assign stat.smp_ok    = (row_cnt < eff_height) && (WW'(col_cnt) < eff_width);
  assign stat.fl_ok     = (row_cnt >= eff_height) && (WW'(fl_cnt) < eff_width);
  assign stat.pend_any  = has_first || has_second;
  assign stat.pend_more = pend_first && pend_second;
  assign stat.tap_last  = (tap == 2'd2);
  assign stat.out_free  = !out_valid || out_ready;

  // ---- flush tap addressing: column fl_cnt - 1 + tap ----
  assign tap_col = CW'(WW'(fl_cnt) + WW'(tap) - WW'(1));
  assign tap_ok  = ((tap != 2'd0) || (fl_cnt != '0)) &&
                   ((tap != 2'd2) || (WW'(fl_cnt) + WW'(1) < eff_width));

  // ---- line stores ----
  assign mem_re  = cmd.load_smp || (cmd.fl_rd && tap_ok);
  assign rd_addr = cmd.load_smp ? col_cnt : tap_col;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      store_a[cap_c] <= cap_smp;
      store_b[cap_c] <= rd_a;
    end
    if (mem_re) begin
      rd_a <= store_a[rd_addr];
      rd_b <= store_b[rd_addr];
    end
  end

  // ---- masked window sum; slot s holds column cap_c - 2 + s ----
  assign row_ok = {1'b1, 1'b1, (cap_r >= HGT_W'(2))};
  assign col_ok = {1'b1, (cap_c != '0), (WW'(cap_c) >= WW'(2)) && pend_first};

  always_comb begin
    win_sum = '0;
    win_cnt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int s = 0; s < 3; s++) begin
        if (row_ok[r] && col_ok[s]) begin
          win_sum = win_sum + SUM_W'(win[3*r+s]);
          win_cnt = win_cnt + CNT_W'(1);
        end
      end
    end
  end

  assign prod = PROD_W'(acc_sum) * PROD_W'(eabs_pkg::recip(acc_cnt));

  assign col_wrap    = (WW'(col_cnt) + WW'(1) >= eff_width);
  assign clear_frame = restart || (cmd.emit && res_flush && res_last);

  // ---- counters, window and pending flags ----
  always_ff @(posedge clk) begin
    if (rst || clear_frame) begin
      col_cnt     <= '0;
      row_cnt     <= '0;
      fl_cnt      <= '0;
      pend_first  <= 1'b0;
      pend_second <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= rd_b;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= rd_a;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= cap_smp;
        pend_first  <= has_first;
        pend_second <= has_second;
        if (col_wrap) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + HGT_W'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (cmd.emit) begin
        if (pend_first) begin
          pend_first <= 1'b0;
        end else begin
          pend_second <= 1'b0;
        end
        if (res_flush) begin
          fl_cnt <= fl_cnt + CW'(1);
        end
      end
    end
  end

  // ---- captured item, accumulator and result fields ----
  always_ff @(posedge clk) begin
    if (cmd.load_smp) begin
      cap_c   <= col_cnt;
      cap_r   <= row_cnt;
      cap_smp <= in_sample;
    end
    if (cmd.sum_win) begin
      acc_sum   <= win_sum;
      acc_cnt   <= win_cnt;
      res_row   <= ROW_W'(cap_r - HGT_W'(1));
      res_col   <= pend_first ? (cap_c - CW'(1)) : cap_c;
      res_last  <= 1'b0;
      res_flush <= 1'b0;
    end
    if (cmd.load_fl) begin
      acc_sum   <= '0;
      acc_cnt   <= '0;
      tap       <= '0;
      res_row   <= ROW_W'(eff_height - HGT_W'(1));
      res_col   <= fl_cnt;
      res_last  <= (WW'(fl_cnt) + WW'(1) == eff_width);
      res_flush <= 1'b1;
    end
    if (cmd.fl_acc) begin
      tap <= tap + 2'd1;
      if (tap_ok) begin
        if (eff_height >= HGT_W'(2)) begin
          acc_sum <= acc_sum + SUM_W'(rd_a) + SUM_W'(rd_b);
          acc_cnt <= acc_cnt + CNT_W'(2);
        end else begin
          acc_sum <= acc_sum + SUM_W'(rd_a);
          acc_cnt <= acc_cnt + CNT_W'(1);
        end
      end
    end
    if (cmd.mul) begin
      quot <= prod[RCP_SH+RES_W-1:RCP_SH];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_smoothed <= quot;
      out_row      <= res_row;
      out_col      <= COL_W'(res_col);
      out_last     <= res_flush && res_last;
    end
  end

endmodule

// ----- hdl/edge_aware_box_smooth_3x3_top.sv -----
// ----------------------------------------------------------------------------
// edge_aware_box_smooth_3x3_top
// Streaming 3x3 neighborhood mean over a raster height grid, 8.8 output.
//
//   channel   dir  handshake                 content
//   s_*       in   s_tvalid / s_tready       tdata: sample; tuser: req_type
//   m_*       out  m_tvalid / m_tready       tdata: smoothed, out_row, out_col;
//                                            tlast: frame_last
//   APB       in   psel, penable, pready=1   grid_width @0x0, grid_height @0x4
//
// Steps: a sample word is written to the line stores and shifted into the
// window, then gives 0, 1 or 2 results; a flush word gives one result from
// its three sequential line store reads. A word that falls outside the frame
// is dropped in its accept cycle. Each result passes the window sum or the
// flush taps, a reciprocal multiply and the output register.
// Reset: synchronous, active high; clears counters, window and output valid.
// Line store contents are not cleared; stale entries are masked by position.
// Stalls: a result held in the output register blocks only the next emit; the
// next word is taken as soon as the sequencer returns to idle.
// ----------------------------------------------------------------------------
module edge_aware_box_smooth_3x3_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] sample
  input  logic        s_tuser,    // [0] req_type (0 sample, 1 flush)
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [15:0] smoothed, [27:16] out_row, [39:28] out_col
  output logic        m_tlast,    // frame_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [eabs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CFG_W = eabs_pkg::CFG_W;
  localparam int HGT_W = eabs_pkg::HGT_W;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [WW-1:0]    eff_width;
  logic [HGT_W-1:0] eff_height;
  logic             cfg_wr;

  eabs_pkg::eabs_cmd_t  cmd;
  eabs_pkg::eabs_stat_t stat;

  logic [eabs_pkg::RES_W-1:0] res_smoothed;
  logic [eabs_pkg::ROW_W-1:0] res_row;
  logic [eabs_pkg::COL_W-1:0] res_col;

  // ---- APB register file; any write restarts the frame ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= eabs_pkg::GRID_RESET;
      grid_height <= eabs_pkg::GRID_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        eabs_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
        eabs_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      eabs_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width);
      eabs_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height);
      default:                   prdata = '0;
    endcase
  end

  // clamp the registers into the supported grid size
  always_comb begin
    if (grid_width == '0) begin
      eff_width = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(grid_width);
    end
  end

  always_comb begin
    if (grid_height == '0) begin
      eff_height = HGT_W'(1);
    end else if (32'(grid_height) > eabs_pkg::MAX_HEIGHT) begin
      eff_height = HGT_W'(eabs_pkg::MAX_HEIGHT);
    end else begin
      eff_height = grid_height;
    end
  end

  eabs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  eabs_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_wr),
    .eff_width    (eff_width),
    .eff_height   (eff_height),
    .in_sample    (s_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_smoothed (res_smoothed),
    .out_row      (res_row),
    .out_col      (res_col),
    .out_last     (m_tlast)
  );

  // pack the result word, first field lowest
  assign m_tdata = {res_col, res_row, res_smoothed};

endmodule
